// ===== design/bq_pkg.sv =====
// ----------------------------------------------------------------------------
// bq_pkg
// Shared types and constants for the direct-form-1 biquad filter.
// ----------------------------------------------------------------------------
`default_nettype none

package bq_pkg;

	localparam int unsigned DATA_W = 16;
	localparam int unsigned IDX_W  = 3;
	localparam int unsigned PROD_W = 2 * DATA_W;

	// term shifts
	localparam int unsigned SHIFT_B0 = 24;
	localparam int unsigned SHIFT_B1 = 23;
	localparam int unsigned SHIFT_B2 = 24;
	localparam int unsigned SHIFT_A1 = 14;
	localparam int unsigned SHIFT_A2 = 15;

	// register indexes
	localparam logic [IDX_W-1:0] REG_B0   = 3'd0;
	localparam logic [IDX_W-1:0] REG_B1   = 3'd1;
	localparam logic [IDX_W-1:0] REG_B2   = 3'd2;
	localparam logic [IDX_W-1:0] REG_A1   = 3'd3;
	localparam logic [IDX_W-1:0] REG_A2   = 3'd4;
	localparam logic [IDX_W-1:0] REG_INIT = 3'd5;

	// reset values
	localparam logic signed [DATA_W-1:0] RST_B0   = 16'sh76B0;
	localparam logic signed [DATA_W-1:0] RST_B1   = 16'sh76B0;
	localparam logic signed [DATA_W-1:0] RST_B2   = 16'sh76B0;
	localparam logic signed [DATA_W-1:0] RST_A1   = 16'sh74A7;
	localparam logic signed [DATA_W-1:0] RST_A2   = 16'sh94D7;
	localparam logic signed [DATA_W-1:0] RST_INIT = 16'shC000;
	localparam logic signed [DATA_W-1:0] RST_YHIST = 16'shC000;

	typedef struct packed {
		logic signed [DATA_W-1:0] b0;
		logic signed [DATA_W-1:0] b1;
		logic signed [DATA_W-1:0] b2;
		logic signed [DATA_W-1:0] a1;
		logic signed [DATA_W-1:0] a2;
	} coef_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] x1;
		logic signed [DATA_W-1:0] x2;
		logic signed [DATA_W-1:0] y1;
		logic signed [DATA_W-1:0] y2;
	} hist_t;

endpackage

`default_nettype wire

// ===== design/bq_term.sv =====
// ----------------------------------------------------------------------------
// bq_term
// One rounded product term: (c * d + 2^(SHIFT-1)) >>> SHIFT.
// ----------------------------------------------------------------------------
`default_nettype none

module bq_term #(
	parameter int unsigned SHIFT = 14
) (
	input  wire logic signed [bq_pkg::DATA_W-1:0]     coef,
	input  wire logic signed [bq_pkg::DATA_W-1:0]     data,
	output logic signed [bq_pkg::PROD_W-SHIFT:0]      term
);

	localparam int unsigned EXT_W = bq_pkg::PROD_W + 1;

	logic signed [bq_pkg::PROD_W-1:0] prod;
	logic signed [EXT_W-1:0]          biased;
	logic signed [EXT_W-1:0]          shifted;

	assign prod    = coef * data;
	assign biased  = EXT_W'(prod) + (EXT_W'(1) <<< (SHIFT - 1));
	assign shifted = biased >>> SHIFT;
	assign term    = shifted[bq_pkg::PROD_W-SHIFT:0];

endmodule

`default_nettype wire

// ===== design/bq_datapath.sv =====
// ----------------------------------------------------------------------------
// bq_datapath
// Five rounded terms summed and wrapped to 16 bits; prime selects init value.
// ----------------------------------------------------------------------------
`default_nettype none

module bq_datapath (
	input  wire bq_pkg::coef_t                   coef,
	input  wire bq_pkg::hist_t                   hist,
	input  wire logic signed [bq_pkg::DATA_W-1:0] init_output,
	input  wire logic signed [bq_pkg::DATA_W-1:0] sample,
	input  wire logic                            prime,
	output logic signed [bq_pkg::DATA_W-1:0]      result
);

	logic signed [bq_pkg::PROD_W-bq_pkg::SHIFT_B0:0] t_b0;
	logic signed [bq_pkg::PROD_W-bq_pkg::SHIFT_B1:0] t_b1;
	logic signed [bq_pkg::PROD_W-bq_pkg::SHIFT_B2:0] t_b2;
	logic signed [bq_pkg::PROD_W-bq_pkg::SHIFT_A1:0] t_a1;
	logic signed [bq_pkg::PROD_W-bq_pkg::SHIFT_A2:0] t_a2;
	logic signed [bq_pkg::DATA_W-1:0]                sum;

	bq_term #(.SHIFT(bq_pkg::SHIFT_B0)) u_b0 (.coef(coef.b0), .data(sample),  .term(t_b0));
	bq_term #(.SHIFT(bq_pkg::SHIFT_B1)) u_b1 (.coef(coef.b1), .data(hist.x1), .term(t_b1));
	bq_term #(.SHIFT(bq_pkg::SHIFT_B2)) u_b2 (.coef(coef.b2), .data(hist.x2), .term(t_b2));
	bq_term #(.SHIFT(bq_pkg::SHIFT_A1)) u_a1 (.coef(coef.a1), .data(hist.y1), .term(t_a1));
	bq_term #(.SHIFT(bq_pkg::SHIFT_A2)) u_a2 (.coef(coef.a2), .data(hist.y2), .term(t_a2));

	// sum wraps modulo 2^16, so each term is taken to 16 bits first
	assign sum = bq_pkg::DATA_W'(t_b0) + bq_pkg::DATA_W'(t_b1) + bq_pkg::DATA_W'(t_b2)
	           + bq_pkg::DATA_W'(t_a1) + bq_pkg::DATA_W'(t_a2);

	assign result = prime ? init_output : sum;

endmodule

`default_nettype wire

// ===== design/biquad_iir_fixed_point.sv =====
// Stages: input stage (sample_s1), then output register (filtered_q).
// Throughput: one sample per cycle while out_ready is high; while a result
// waits, one more sample fills the input stage, then in_ready drops. The path
// from the history registers through the multipliers and adder sets the clock.
// Reset: coefficients and init_output take their defaults, input history 0,
// output history 0xC000, both stages empty.
// ----------------------------------------------------------------------------
// biquad_iir_fixed_point
// Direct-form-1 second-order IIR filter, signed 16-bit, wrapped output.
// ----------------------------------------------------------------------------
`default_nettype none

module biquad_iir_fixed_point (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              wr_en,
	input  wire logic [bq_pkg::IDX_W-1:0]          wr_index,
	input  wire logic [bq_pkg::DATA_W-1:0]         wr_data,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic signed [bq_pkg::DATA_W-1:0]  sample,
	input  wire logic                              prime,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic signed [bq_pkg::DATA_W-1:0]       filtered
);

	bq_pkg::coef_t                   coef_q;
	logic signed [bq_pkg::DATA_W-1:0] init_q;
	bq_pkg::hist_t                   hist_q;

	logic                            valid_s1;
	logic signed [bq_pkg::DATA_W-1:0] sample_s1;
	logic                            prime_s1;

	logic                            out_valid_q;
	logic signed [bq_pkg::DATA_W-1:0] filtered_q;

	logic                            advance;
	logic signed [bq_pkg::DATA_W-1:0] result;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.b0 <= bq_pkg::RST_B0;
			coef_q.b1 <= bq_pkg::RST_B1;
			coef_q.b2 <= bq_pkg::RST_B2;
			coef_q.a1 <= bq_pkg::RST_A1;
			coef_q.a2 <= bq_pkg::RST_A2;
			init_q    <= bq_pkg::RST_INIT;
		end else if (wr_en) begin
			case (wr_index)
				bq_pkg::REG_B0:   coef_q.b0 <= wr_data;
				bq_pkg::REG_B1:   coef_q.b1 <= wr_data;
				bq_pkg::REG_B2:   coef_q.b2 <= wr_data;
				bq_pkg::REG_A1:   coef_q.a1 <= wr_data;
				bq_pkg::REG_A2:   coef_q.a2 <= wr_data;
				bq_pkg::REG_INIT: init_q    <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sample_s1 <= sample;
			prime_s1  <= prime;
		end
	end

	bq_datapath u_datapath (
		.coef        (coef_q),
		.hist        (hist_q),
		.init_output (init_q),
		.sample      (sample_s1),
		.prime       (prime_s1),
		.result      (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q.x1 <= '0;
			hist_q.x2 <= '0;
			hist_q.y1 <= bq_pkg::RST_YHIST;
			hist_q.y2 <= bq_pkg::RST_YHIST;
		end else if (advance) begin
			hist_q.x1 <= sample_s1;
			hist_q.x2 <= hist_q.x1;
			hist_q.y1 <= result;
			hist_q.y2 <= hist_q.y1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			filtered_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign filtered  = filtered_q;

endmodule

`default_nettype wire

// ===== bench/tb_biquad_iir_fixed_point.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_biquad_iir_fixed_point
// Self-checking bench for the direct-form-1 biquad. Samples and prime
// transactions go in under valid/ready with random gaps, and results come
// out under random back-pressure, both off in the closing stretch. Each
// result is checked against a bit-exact model of the filter arithmetic. The
// coefficient set changes between phases: reset values, extremes, random sets.
// ----------------------------------------------------------------------------

module tb_biquad_iir_fixed_point;

	localparam int CLK_PERIOD     = 12;
	localparam int HOLD_CYCLES    = 64;
	localparam int TIMEOUT_CYCLES = 200000;
	localparam logic signed [bq_pkg::DATA_W-1:0] SMAX = 16'sh7FFF;
	localparam logic signed [bq_pkg::DATA_W-1:0] SMIN = 16'sh8000;

	class biquad_tracker_t;
		logic signed [bq_pkg::DATA_W-1:0] coef [5];
		logic signed [bq_pkg::DATA_W-1:0] init_y;
		logic signed [bq_pkg::DATA_W-1:0] x1, x2, y1, y2;
		logic signed [bq_pkg::DATA_W-1:0] expected_filtered [$];
		int errors;
		int results_seen;

		function new();
			errors                 = 0;
			results_seen           = 0;
			coef[bq_pkg::REG_B0]   = bq_pkg::RST_B0;
			coef[bq_pkg::REG_B1]   = bq_pkg::RST_B1;
			coef[bq_pkg::REG_B2]   = bq_pkg::RST_B2;
			coef[bq_pkg::REG_A1]   = bq_pkg::RST_A1;
			coef[bq_pkg::REG_A2]   = bq_pkg::RST_A2;
			init_y                 = bq_pkg::RST_INIT;
			x1                     = '0;
			x2                     = '0;
			y1                     = bq_pkg::RST_YHIST;
			y2                     = bq_pkg::RST_YHIST;
		endfunction

		function void write_reg(logic [bq_pkg::IDX_W-1:0] idx,
				logic [bq_pkg::DATA_W-1:0] data);
			if (idx == bq_pkg::REG_INIT)
				init_y = data;
			else if (idx <= bq_pkg::REG_A2)
				coef[idx] = data;
		endfunction

		// product plus half an LSB, then floor shift
		function longint rounded_term(logic signed [bq_pkg::DATA_W-1:0] c,
				logic signed [bq_pkg::DATA_W-1:0] d, int unsigned s);
			longint p;
			p = longint'(c) * longint'(d) + (longint'(1) << (s - 1));
			return p >>> s;
		endfunction

		function void note_sample(logic signed [bq_pkg::DATA_W-1:0] s, logic p);
			logic signed [bq_pkg::DATA_W-1:0] y;
			longint sum;
			if (p) begin
				y = init_y;
			end else begin
				sum = rounded_term(coef[bq_pkg::REG_B0], s,  bq_pkg::SHIFT_B0)
					+ rounded_term(coef[bq_pkg::REG_B1], x1, bq_pkg::SHIFT_B1)
					+ rounded_term(coef[bq_pkg::REG_B2], x2, bq_pkg::SHIFT_B2)
					+ rounded_term(coef[bq_pkg::REG_A1], y1, bq_pkg::SHIFT_A1)
					+ rounded_term(coef[bq_pkg::REG_A2], y2, bq_pkg::SHIFT_A2);
				y = bq_pkg::DATA_W'(sum);
			end
			x2 = x1;
			x1 = s;
			y2 = y1;
			y1 = y;
			expected_filtered.push_back(y);
		endfunction

		function void check_filtered(logic signed [bq_pkg::DATA_W-1:0] got);
			logic signed [bq_pkg::DATA_W-1:0] want;
			results_seen++;
			if (expected_filtered.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("MISMATCH result %0d: nothing outstanding, got %0d",
						results_seen, got);
				return;
			end
			want = expected_filtered.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10)
					$display("MISMATCH result %0d: filtered expected %0d, got %0d",
						results_seen, want, got);
			end
		endfunction

		function int pending();
			return expected_filtered.size();
		endfunction
	endclass

	logic                              clk;
	logic                              arst_n;
	logic                              wr_en;
	logic [bq_pkg::IDX_W-1:0]          wr_index;
	logic [bq_pkg::DATA_W-1:0]         wr_data;
	logic                              in_valid;
	logic                              in_ready;
	logic signed [bq_pkg::DATA_W-1:0]  sample;
	logic                              prime;
	logic                              out_valid;
	logic                              out_ready;
	logic signed [bq_pkg::DATA_W-1:0]  filtered;

	biquad_tracker_t tracker;
	bit gaps_on;
	bit stalls_on;
	bit hold_req;

	biquad_iir_fixed_point DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample    (sample),
		.prime     (prime),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.filtered  (filtered)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("biquad_iir_fixed_point verification failed");
		$finish;
	end

	function automatic logic signed [bq_pkg::DATA_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return SMAX;
			1: return SMIN;
			2: return '0;
			3: return bq_pkg::DATA_W'(int'($urandom_range(0, 31)) - 16);
			default: return bq_pkg::DATA_W'($urandom);
		endcase
	endfunction

	task automatic send_item(input logic signed [bq_pkg::DATA_W-1:0] s, input logic p);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		in_valid <= 1'b1;
		sample   <= s;
		prime    <= p;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		tracker.note_sample(s, p);
		@(negedge clk);
	endtask

	task automatic send_random();
		send_item(pick_value(), $urandom_range(0, 9) == 0);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (tracker.pending() != 0) @(negedge clk);
	endtask

	// unused indexes get random data; the block must ignore them
	task automatic load_config(input bq_pkg::coef_t c,
			input logic signed [bq_pkg::DATA_W-1:0] init);
		logic [bq_pkg::DATA_W-1:0] vals [1 << bq_pkg::IDX_W];
		foreach (vals[i]) vals[i] = bq_pkg::DATA_W'($urandom);
		vals[bq_pkg::REG_B0]   = c.b0;
		vals[bq_pkg::REG_B1]   = c.b1;
		vals[bq_pkg::REG_B2]   = c.b2;
		vals[bq_pkg::REG_A1]   = c.a1;
		vals[bq_pkg::REG_A2]   = c.a2;
		vals[bq_pkg::REG_INIT] = init;
		for (int i = 0; i < (1 << bq_pkg::IDX_W); i++) begin
			wr_en    <= 1'b1;
			wr_index <= bq_pkg::IDX_W'(i);
			wr_data  <= vals[i];
			tracker.write_reg(bq_pkg::IDX_W'(i), vals[i]);
			@(negedge clk);
		end
		wr_en <= 1'b0;
	endtask

	task automatic load_random_config();
		bq_pkg::coef_t c;
		c.b0 = pick_value();
		c.b1 = pick_value();
		c.b2 = pick_value();
		c.a1 = pick_value();
		c.a2 = pick_value();
		load_config(c, pick_value());
	endtask

	task automatic run_extremes();
		send_item(SMAX, 1'b0);
		send_item(SMAX, 1'b0);
		send_item(SMIN, 1'b0);
		send_item(SMIN, 1'b0);
		send_item(SMAX, 1'b1);
		send_item('0, 1'b0);
	endtask

	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_req = 1'b0;
			end else if (stalls_on && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(0, 2)) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.check_filtered(filtered);
	end

	initial begin
		tracker   = new();
		arst_n    = 1'b0;
		wr_en     = 1'b0;
		wr_index  = '0;
		wr_data   = '0;
		in_valid  = 1'b0;
		sample    = '0;
		prime     = 1'b0;
		gaps_on   = 1'b1;
		stalls_on = 1'b1;
		hold_req  = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset coefficients and histories
		send_item('0, 1'b0);
		send_item(SMAX, 1'b0);
		send_item(SMAX, 1'b0);
		send_item(SMIN, 1'b0);
		send_item(SMIN, 1'b0);
		send_item(-16'sd1, 1'b0);
		send_item(16'sh1234, 1'b1);
		send_item(SMIN, 1'b1);
		send_item(SMAX, 1'b0);
		send_item(16'sd1, 1'b0);

		wait_idle();
		load_config('{SMAX, SMAX, SMAX, SMAX, SMAX}, SMAX);
		run_extremes();
		wait_idle();
		load_config('{SMIN, SMIN, SMIN, SMIN, SMIN}, SMIN);
		run_extremes();

		for (int ph = 0; ph < 6; ph++) begin
			wait_idle();
			load_random_config();
			if (ph == 2)
				hold_req = 1'b1;
			for (int n = 0; n < 60; n++) begin
				if (ph == 3 && n == 30)
					wait_idle();
				send_random();
			end
		end

		// closing stretch at full rate
		wait_idle();
		gaps_on   = 1'b0;
		stalls_on = 1'b0;
		load_random_config();
		repeat (40) send_random();

		wait_idle();
		repeat (4) @(negedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0) begin
			$display("biquad_iir_fixed_point verification clean");
		end else begin
			$display("biquad_iir_fixed_point verification failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
design/bq_pkg.sv
design/bq_term.sv
design/bq_datapath.sv
design/biquad_iir_fixed_point.sv
bench/tb_biquad_iir_fixed_point.sv
